@@ rtl/core/lzwd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzwd_pkg: shared types and constants of the LZ77 window decompressor
// Item formats of both channels, header and token constants, parameter
// defaults.
// ----------------------------------------------------------------------------
package lzwd_pkg;

   localparam int WINDOW_DEPTH_DEF = 4096;   // power of two, 16..4096
   localparam int MAX_MATCH_DEF    = 18;     // 3..18

   localparam int SIZE_W = 24;               // declared output size

   localparam logic [2:0] HDR_DONE    = 3'd4;  // all four header bytes seen
   localparam logic [3:0] FLAG_BLOCKS = 4'd8;  // blocks governed by a flag byte
   localparam logic [4:0] LEN_BIAS    = 5'd3;  // token length offset

   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_start;
   } req_type;

   typedef struct packed {
      logic [15:0] out_data;
      logic        out_last;
      logic        stream_done;
      logic        overrun;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/core/lz77_window_decompressor.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lz77_window_decompressor: type-10 LZ77 stream decoder
// Decodes a compressed byte stream through a history RAM and emits bytes
// or little-endian halfwords.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  req       in   req_valid / req_stall  req_data  (in_byte, stream_start)
//  rsp       out  rsp_valid / rsp_stall  rsp_data  (out_data, out_last,
//                                                   stream_done, overrun)
//  csr       in   csr_write_en           csr_write_data (output_mode)
//
//  Header and flag bytes only update parse state; literals and copies go
//  through the byte stage. On its single read port the history RAM yields one
//  byte per cycle unless that stage is held, each written back as it is emitted.
//  Synchronous reset clears control state; the history RAM is not cleared.
//  A stalled result holds the byte stage when its byte would produce a result,
//  and req_stall stays high while a decoded byte is still waiting in that stage.
// ----------------------------------------------------------------------------
module lz77_window_decompressor
   import lzwd_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
   parameter int MAX_MATCH    = MAX_MATCH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   input  wire logic    csr_write_en,
   input  wire logic    csr_write_data
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int LW = $clog2(MAX_MATCH + 1);

   // history RAM
   logic [7:0] hist_mem [WINDOW_DEPTH];
   logic [7:0] mem_q_ff;

   // stream state
   logic [AW-1:0]     wp_ff, wp_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [2:0]        hdr_ff, hdr_in;
   logic [7:0]        flags_ff, flags_in;
   logic [3:0]        blocks_ff, blocks_in;
   logic [7:0]        tok_hi_ff, tok_hi_in;
   logic              phase_ff, phase_in;
   logic              pend_vld_ff, pend_vld_in;
   logic [7:0]        pend_byte_ff, pend_byte_in;
   logic              err_ff, err_in;
   logic              mode_ff;

   // byte stage and copy control
   logic              byte_vld_ff, byte_vld_in;
   logic              lit_sel_ff, lit_sel_in;
   logic [7:0]        lit_ff, lit_in;
   logic [LW-1:0]     rd_left_ff, rd_left_in;
   logic [LW-1:0]     item_left_ff, item_left_in;
   logic [AW-1:0]     src_ff, src_in;
   logic              fwd_ff, fwd_in;
   logic [7:0]        fwd_data_ff, fwd_data_in;

   // result register
   logic              rsp_vld_ff, rsp_vld_in;
   rsp_type           rsp_ff, rsp_in;

   logic              acc;
   logic              mem_re;
   logic [AW-1:0]     rd_addr;
   logic [7:0]        cur_byte;
   logic              out_free;
   logic              needs_out;
   logic              consume;
   logic [SIZE_W-1:0] rem_after;
   logic              err_after;
   logic [15:0]       tok;
   logic [12:0]       dist_raw;
   logic [AW-1:0]     copy_src;
   logic [4:0]        len_raw;
   logic [LW-1:0]     copy_len;

   assign req_stall = byte_vld_ff;
   assign acc       = req_valid && !byte_vld_ff;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // a read of the entry written in the same cycle takes the written byte
   assign cur_byte  = lit_sel_ff ? lit_ff : (fwd_ff ? fwd_data_ff : mem_q_ff);
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign needs_out = !mode_ff || pend_vld_ff;
   assign consume   = byte_vld_ff && (!needs_out || out_free);
   assign rem_after = (rem_ff != '0) ? rem_ff - SIZE_W'(1) : '0;
   assign err_after = err_ff || (rem_ff == '0);

   assign tok      = {tok_hi_ff, req_data.in_byte};
   assign dist_raw = {1'b0, tok[11:0]} + 13'd1;
   assign copy_src = wp_ff - dist_raw[AW-1:0];
   assign len_raw  = {1'b0, tok[15:12]} + LEN_BIAS;
   assign copy_len = (len_raw > 5'(MAX_MATCH)) ? LW'(MAX_MATCH) : LW'(len_raw);

   always_comb begin
      wp_in        = wp_ff;
      rem_in       = rem_ff;
      hdr_in       = hdr_ff;
      flags_in     = flags_ff;
      blocks_in    = blocks_ff;
      tok_hi_in    = tok_hi_ff;
      phase_in     = phase_ff;
      pend_vld_in  = pend_vld_ff;
      pend_byte_in = pend_byte_ff;
      err_in       = err_ff;
      byte_vld_in  = byte_vld_ff;
      lit_sel_in   = lit_sel_ff;
      lit_in       = lit_ff;
      rd_left_in   = rd_left_ff;
      item_left_in = item_left_ff;
      src_in       = src_ff;
      fwd_in       = fwd_ff;
      fwd_data_in  = fwd_data_ff;
      rsp_in       = rsp_ff;
      rsp_vld_in   = rsp_vld_ff && rsp_stall;
      mem_re       = 1'b0;
      rd_addr      = src_ff;

      if (consume) begin
         wp_in        = wp_ff + AW'(1);
         rem_in       = rem_after;
         err_in       = err_after;
         item_left_in = item_left_ff - LW'(1);
         if (needs_out) begin
            rsp_vld_in           = 1'b1;
            rsp_in.out_data      = mode_ff ? {cur_byte, pend_byte_ff} : {8'h00, cur_byte};
            // in halfword mode a trailing single byte makes no result
            rsp_in.out_last      = mode_ff ? (item_left_ff <= LW'(2))
                                           : (item_left_ff == LW'(1));
            rsp_in.stream_done   = (rem_after == '0);
            rsp_in.overrun       = err_after;
         end
         if (mode_ff) begin
            if (pend_vld_ff) begin
               pend_vld_in = 1'b0;
            end else begin
               pend_vld_in  = 1'b1;
               pend_byte_in = cur_byte;
            end
         end
         if (rd_left_ff != '0) begin
            mem_re     = 1'b1;
            rd_addr    = src_ff;
            src_in     = src_ff + AW'(1);
            rd_left_in = rd_left_ff - LW'(1);
         end else begin
            byte_vld_in = 1'b0;
         end
         if (item_left_ff == LW'(1) && rem_after == '0) begin
            pend_vld_in = 1'b0;
         end
      end

      if (acc) begin
         if (req_data.stream_start) begin
            rem_in      = '0;
            hdr_in      = '0;
            flags_in    = '0;
            blocks_in   = '0;
            tok_hi_in   = '0;
            phase_in    = 1'b0;
            pend_vld_in = 1'b0;
            err_in      = 1'b0;
         end
         if (hdr_in < HDR_DONE) begin
            // header byte 0 is the type byte, bytes 1..3 the size
            if (hdr_in != '0) begin
               rem_in = rem_in | (SIZE_W'(req_data.in_byte) << {hdr_in - 3'd1, 3'b000});
            end
            hdr_in = hdr_in + 3'd1;
         end else if (rem_in == '0) begin
            // stream finished: byte ignored
         end else if (blocks_in == '0) begin
            flags_in  = req_data.in_byte;
            blocks_in = FLAG_BLOCKS;
         end else if (flags_in[7] && !phase_in) begin
            tok_hi_in = req_data.in_byte;
            phase_in  = 1'b1;
         end else begin
            if (flags_in[7]) begin
               phase_in     = 1'b0;
               mem_re       = 1'b1;
               rd_addr      = copy_src;
               src_in       = copy_src + AW'(1);
               item_left_in = copy_len;
               rd_left_in   = copy_len - LW'(1);
               lit_sel_in   = 1'b0;
            end else begin
               lit_sel_in   = 1'b1;
               lit_in       = req_data.in_byte;
               item_left_in = LW'(1);
               rd_left_in   = '0;
            end
            byte_vld_in = 1'b1;
            flags_in    = {flags_in[6:0], 1'b0};
            blocks_in   = blocks_in - 4'd1;
         end
      end

      if (mem_re) begin
         fwd_in      = consume && (rd_addr == wp_ff);
         fwd_data_in = cur_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (consume) begin
         hist_mem[wp_ff] <= cur_byte;
      end
      if (mem_re) begin
         mem_q_ff <= hist_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rem_ff       <= '0;
         hdr_ff       <= '0;
         flags_ff     <= '0;
         blocks_ff    <= '0;
         tok_hi_ff    <= '0;
         phase_ff     <= 1'b0;
         pend_vld_ff  <= 1'b0;
         err_ff       <= 1'b0;
         mode_ff      <= 1'b0;
         byte_vld_ff  <= 1'b0;
         lit_sel_ff   <= 1'b0;
         rd_left_ff   <= '0;
         item_left_ff <= '0;
         fwd_ff       <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         rem_ff       <= rem_in;
         hdr_ff       <= hdr_in;
         flags_ff     <= flags_in;
         blocks_ff    <= blocks_in;
         tok_hi_ff    <= tok_hi_in;
         phase_ff     <= phase_in;
         pend_vld_ff  <= pend_vld_in;
         err_ff       <= err_in;
         if (csr_write_en) begin
            mode_ff <= csr_write_data;
         end
         byte_vld_ff  <= byte_vld_in;
         lit_sel_ff   <= lit_sel_in;
         rd_left_ff   <= rd_left_in;
         item_left_ff <= item_left_in;
         fwd_ff       <= fwd_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
      lit_ff       <= lit_in;
      src_ff       <= src_in;
      fwd_data_ff  <= fwd_data_in;
      rsp_ff       <= rsp_in;
   end

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lz77_window_decompressor
// Feeds compressed streams through the request channel under random idling
// and back-pressure, decodes every accepted item in a local model of the
// decoder and checks each result field by field, in order.
// ----------------------------------------------------------------------------
module testbench
   import lzwd_pkg::*;
();

   localparam int DRAIN_CYCLES   = 2 * (MAX_MATCH_DEF + 2);
   localparam int LONG_HOLD      = 150;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_ITEMS    = 70;

   typedef enum logic [1:0] {DEC_NONE, DEC_LITERAL, DEC_COPY} dec_act_type;

   // stream parse state, shared by the stimulus shaper and the decoder model
   typedef struct packed {
      logic [2:0]  hdr_cnt;
      logic [23:0] remaining;
      logic [7:0]  flags;
      logic [3:0]  blocks;
      logic [7:0]  tok_hi;
      logic        tok_phase;
   } ctl_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_write_en = 1'b0;
   logic    csr_write_data = 1'b0;

   // decoder model
   logic [7:0]  window_mem [WINDOW_DEPTH_DEF];
   logic [11:0] wr_ptr = '0;
   ctl_type     decoder_ctl = '0;
   logic [8:0]  held_low = '0;
   logic        corrupt = 1'b0;
   logic        half_mode = 1'b0;
   rsp_type     decoded_words [$];

   // stimulus
   req_type stream_bytes [$];
   ctl_type shaper_ctl = '0;
   int      history_fill = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   logic    hold_armed = 1'b0;
   int      hold_cycles = 0;

   int mismatches = 0;
   int accepted_items = 0;
   int checked_words = 0;
   int halfwords = 0;
   int overrun_words = 0;
   int streams = 0;
   int quiet_cycles = 0;

   lz77_window_decompressor u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #4 clock = ~clock;

   // Parses one byte; returns what it decodes: nothing, a literal, or a copy
   // of run bytes starting span+1 bytes back.
   function automatic dec_act_type advance_decoder(inout ctl_type c, input req_type item,
                                                   output logic [11:0] span,
                                                   output logic [4:0] run);
      logic [15:0] tok;
      dec_act_type act;
      span = '0;
      run  = '0;
      act  = DEC_NONE;
      if (item.stream_start)
         c = '0;
      if (c.hdr_cnt < HDR_DONE) begin
         if (c.hdr_cnt != 3'd0)
            c.remaining = c.remaining |
                          ({16'd0, item.in_byte} << {c.hdr_cnt - 3'd1, 3'b000});
         c.hdr_cnt = c.hdr_cnt + 3'd1;
      end else if (c.remaining != '0) begin
         if (c.blocks == 4'd0) begin
            c.flags  = item.in_byte;
            c.blocks = FLAG_BLOCKS;
         end else if (c.flags[7] && !c.tok_phase) begin
            c.tok_hi    = item.in_byte;
            c.tok_phase = 1'b1;
         end else begin
            if (c.flags[7]) begin
               tok  = {c.tok_hi, item.in_byte};
               span = tok[11:0];
               run  = tok[15:12] + LEN_BIAS;
               if (run > MAX_MATCH_DEF)
                  run = 5'(MAX_MATCH_DEF);
               c.tok_phase = 1'b0;
               act = DEC_COPY;
            end else begin
               run = 5'd1;
               act = DEC_LITERAL;
            end
            c.remaining = (c.remaining > run) ? c.remaining - run : '0;
            c.flags  = c.flags << 1;
            c.blocks = c.blocks - 4'd1;
         end
      end
      return act;
   endfunction

   function automatic logic stream_finished(input ctl_type c);
      return c.hdr_cnt == HDR_DONE && c.remaining == '0;
   endfunction

   task automatic decode_item(input req_type item);
      dec_act_type act;
      logic [11:0] span;
      logic [11:0] src;
      logic [4:0]  run;
      logic [23:0] left;
      logic [7:0]  b;
      logic        emit;
      rsp_type     word;
      int          first;
      int          i;
      if (item.stream_start) begin
         held_low = '0;
         corrupt  = 1'b0;
      end
      left  = item.stream_start ? '0 : decoder_ctl.remaining;
      act   = advance_decoder(decoder_ctl, item, span, run);
      first = decoded_words.size();
      src   = wr_ptr - span - 12'd1;
      for (i = 0; i < run; i++) begin
         b = (act == DEC_COPY) ? window_mem[src] : item.in_byte;
         src = src + 12'd1;
         window_mem[wr_ptr] = b;
         wr_ptr = wr_ptr + 12'd1;
         if (left != '0)
            left = left - 24'd1;
         else
            corrupt = 1'b1;
         word = '0;
         emit = 1'b1;
         if (!half_mode) begin
            word.out_data = {8'h00, b};
         end else if (held_low[8]) begin
            word.out_data = {b, held_low[7:0]};
            held_low = '0;
            halfwords++;
         end else begin
            held_low = {1'b1, b};
            emit = 1'b0;
         end
         if (emit) begin
            word.stream_done = (left == '0);
            word.overrun     = corrupt;
            if (corrupt)
               overrun_words++;
            decoded_words.push_back(word);
         end
      end
      // an odd byte left over at the end of a stream is dropped
      if (act != DEC_NONE && left == '0)
         held_low = '0;
      if (decoded_words.size() > first) begin
         word = decoded_words.pop_back();
         word.out_last = 1'b1;
         decoded_words.push_back(word);
      end
   endtask

   // Queues one byte. Token bytes are bent so that a copy never reaches a
   // history entry that nothing has written since reset.
   task automatic queue_item(input logic [7:0] b, input logic start);
      req_type     item;
      ctl_type     c;
      logic [11:0] span;
      logic [4:0]  run;
      dec_act_type act;
      int          lim;
      item.in_byte      = b;
      item.stream_start = start;
      c = start ? '0 : shaper_ctl;
      lim = history_fill - 1;
      if (!stream_finished(c) && c.hdr_cnt == HDR_DONE && history_fill < WINDOW_DEPTH_DEF) begin
         if (c.blocks == 4'd0) begin
            if (history_fill == 0)
               item.in_byte[7] = 1'b0;
         end else if (c.flags[7] && !c.tok_phase) begin
            if (item.in_byte[3:0] > (lim >> 8))
               item.in_byte[3:0] = 4'(lim >> 8);
         end else if (c.flags[7] && {c.tok_hi[3:0], item.in_byte} > lim) begin
            item.in_byte = 8'($urandom_range(lim - c.tok_hi[3:0] * 256, 0));
         end
      end
      if (start)
         streams++;
      act = advance_decoder(shaper_ctl, item, span, run);
      history_fill = history_fill + run;
      if (history_fill > WINDOW_DEPTH_DEF)
         history_fill = WINDOW_DEPTH_DEF;
      stream_bytes.push_back(item);
   endtask

   task automatic random_streams(input int target);
      int made;
      int cut_at;
      int k;
      int pick;
      logic [23:0] sz;
      made   = 0;
      cut_at = -1;
      k      = 0;
      while (made < target) begin
         if (stream_finished(shaper_ctl) && $urandom_range(99, 0) < 8) begin
            queue_item(8'($urandom_range(255, 0)), 1'b0);   // ignored by a finished stream
         end else if (stream_finished(shaper_ctl) || k == cut_at) begin
            pick = $urandom_range(99, 0);
            if (pick < 8)
               sz = '0;
            else if (pick < 16)
               sz = (pick == 8) ? 24'hFFFFFF : 24'($urandom_range(24'hFFFFFF, 24'h000100));
            else if (pick < 26)
               sz = 24'($urandom_range(200, 60));
            else
               sz = 24'($urandom_range(40, 1));
            // huge streams always get a cut point for an early next start
            cut_at = (sz > 24'd200 || $urandom_range(99, 0) < 6) ? $urandom_range(30, 4) : -1;
            k = 0;
            queue_item(8'($urandom_range(255, 0)), 1'b1);
            queue_item(sz[7:0], 1'b0);
            queue_item(sz[15:8], 1'b0);
            queue_item(sz[23:16], 1'b0);
            made += 4;
         end else begin
            queue_item(8'($urandom_range(255, 0)), 1'b0);
            k++;
            made++;
         end
      end
   endtask

   task automatic drain();
      while (stream_bytes.size() != 0 || req_valid || decoded_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= mode;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      half_mode = mode;
   endtask

   task automatic report_field(input string field, input int want, input int got);
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      mismatches++;
   endtask

   // request driver: holds each item until it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_item(req_data);
            accepted_items++;
         end
         if (!req_valid || !req_stall) begin
            if (stream_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_data  <= stream_bytes.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked_words++;
            if (decoded_words.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = decoded_words.pop_front();
               if (rsp_data.out_data !== want.out_data)
                  report_field("out_data", int'(want.out_data), int'(rsp_data.out_data));
               if (rsp_data.out_last !== want.out_last)
                  report_field("out_last", int'(want.out_last), int'(rsp_data.out_last));
               if (rsp_data.stream_done !== want.stream_done)
                  report_field("stream_done", int'(want.stream_done),
                               int'(rsp_data.stream_done));
               if (rsp_data.overrun !== want.overrun)
                  report_field("overrun", int'(want.overrun), int'(rsp_data.overrun));
            end
         end
         if (hold_armed && hold_cycles < LONG_HOLD) begin
            rsp_stall <= 1'b1;
            hold_cycles++;
         end else begin
            rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("testbench: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 34;
      recv_idle_pct = 73;
      write_mode(1'b0);

      // first stream right after reset, without a start mark
      queue_item(8'h10, 1'b0);
      queue_item(8'h02, 1'b0);
      queue_item(8'h00, 1'b0);
      queue_item(8'h00, 1'b0);
      queue_item(8'h00, 1'b0);
      queue_item(8'h00, 1'b0);
      queue_item(8'hFF, 1'b0);
      queue_item(8'hFF, 1'b0);   // stream done, ignored
      // zero size: finishes with no output
      queue_item(8'h10, 1'b1);
      queue_item(8'h00, 1'b0);
      queue_item(8'h00, 1'b0);
      queue_item(8'h00, 1'b0);
      drain();

      // halfwords: literal then longest copy at distance 1, one byte left
      write_mode(1'b1);
      queue_item(8'h10, 1'b1);
      queue_item(8'h14, 1'b0);
      queue_item(8'h00, 1'b0);
      queue_item(8'h00, 1'b0);
      queue_item(8'h40, 1'b0);
      queue_item(8'h7F, 1'b0);
      queue_item(8'hF0, 1'b0);
      queue_item(8'h00, 1'b0);
      drain();

      // back to bytes with a low byte still held, then a copy past the size
      write_mode(1'b0);
      queue_item(8'h01, 1'b0);
      queue_item(8'h10, 1'b1);
      queue_item(8'h02, 1'b0);
      queue_item(8'h00, 1'b0);
      queue_item(8'h00, 1'b0);
      queue_item(8'h80, 1'b0);
      queue_item(8'h10, 1'b0);
      queue_item(8'h00, 1'b0);
      drain();

      write_mode(1'b1);
      hold_armed = 1'b1;
      random_streams(PHASE_ITEMS);
      drain();

      write_mode(1'b0);
      send_idle_pct = 73;
      recv_idle_pct = 34;
      random_streams(PHASE_ITEMS);
      drain();

      write_mode(1'b1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_streams(PHASE_ITEMS);
      drain();

      $display("%0d items in %0d started streams, %0d results checked", accepted_items,
               streams, checked_words);
      $display("%0d halfword results, %0d past declared size, receiver held off %0d cycles",
               halfwords, overrun_words, hold_cycles);
      if (mismatches == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
